>>> sv/ccfd_pkg.sv
package ccfd_pkg;

    localparam int FRAME_CAP    = 64;
    localparam int NUM_CHANNELS = 16;
    localparam int CH_BYTES     = 22;
    localparam int CH_BITS      = 11;
    localparam int FIRST_CH_POS = 3;
    localparam int FQ_DEPTH     = 2;

    localparam int COUNT_W    = 7;
    localparam int POS_W      = 9;
    localparam int CH_IDX_W   = 4;
    localparam int VALUE_W    = 27;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
    localparam logic [7:0]         ADDR_RC    = 8'hEE;
    localparam logic [7:0]         TYPE_RC    = 8'h16;
    localparam logic [7:0]         MIN_RC_LEN = 8'd24;

    localparam logic [7:0]         CRC_POLY_RESET     = 8'd213;
    localparam logic [SCALE_W-1:0] SCALE_MULT_RESET   = 16'd2;
    localparam logic [SCALE_W-1:0] SCALE_DIV_RESET    = 16'd1;
    localparam logic [SCALE_W-1:0] SCALE_OFFSET_RESET = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRC_POLY     = 2'd0,
        REG_SCALE_MULT   = 2'd1,
        REG_SCALE_DIV    = 2'd2,
        REG_SCALE_OFFSET = 2'd3
    } cfg_reg_t;

    typedef logic [CH_BYTES*8-1:0] ch_bytes_t;

    typedef struct packed {
        logic      push;
        ch_bytes_t bytes;
    } fq_wr_t;

    typedef struct packed {
        logic      valid;
        ch_bytes_t bytes;
    } fq_rd_t;

    function automatic logic [7:0] crc8_update(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> sv/ccfd_front.sv
module ccfd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    q_full,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_frame,
    input  logic                    line_error,
    input  logic [7:0]              crc_poly,
    output ccfd_pkg::fq_wr_t        fq_wr
);

    logic                          accept;
    logic [ccfd_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [7:0]                    addr_reg, addr_next;
    logic [7:0]                    len_reg, len_next;
    logic [7:0]                    type_reg, type_next;
    logic [7:0]                    crc_reg, crc_next;
    logic                          matched_reg, matched_next;
    logic                          discard_reg, discard_next;
    ccfd_pkg::ch_bytes_t           ch_reg, ch_next;
    logic [ccfd_pkg::POS_W-1:0]    pos;
    logic [ccfd_pkg::POS_W-1:0]    len_old;
    logic [ccfd_pkg::POS_W-1:0]    len_new;
    logic                          frame_ok;

    assign accept  = push && !q_full;
    assign pos     = {2'b00, count_reg};
    assign len_old = {1'b0, len_reg};
    assign len_new = {1'b0, len_next};

    always_comb
    begin
        count_next   = count_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        type_next    = type_reg;
        crc_next     = crc_reg;
        matched_next = matched_reg;
        discard_next = discard_reg;
        ch_next      = ch_reg;
        if (accept)
        begin
            if (line_error)
            begin
                discard_next = 1'b1;
            end
            else if (count_reg != ccfd_pkg::COUNT_MAX)
            begin
                if (pos < ccfd_pkg::POS_W'(ccfd_pkg::FRAME_CAP))
                begin
                    if (pos == ccfd_pkg::POS_W'(0))
                    begin
                        addr_next = data_byte;
                    end
                    else if (pos == ccfd_pkg::POS_W'(1))
                    begin
                        len_next = data_byte;
                    end
                    else if (pos <= len_old)
                    begin
                        crc_next = ccfd_pkg::crc8_update(crc_reg, data_byte, crc_poly);
                        if (pos == ccfd_pkg::POS_W'(2))
                        begin
                            type_next = data_byte;
                        end
                        for (int i = 0; i < ccfd_pkg::CH_BYTES; i++)
                        begin
                            if (pos == ccfd_pkg::POS_W'(i + ccfd_pkg::FIRST_CH_POS))
                            begin
                                ch_next[i*8 +: 8] = data_byte;
                            end
                        end
                    end
                    else if (pos == len_old + ccfd_pkg::POS_W'(1))
                    begin
                        matched_next = (data_byte == crc_reg);
                    end
                end
                count_next = count_reg + ccfd_pkg::COUNT_W'(1);
            end
        end
    end

    // The frame check looks at the state as it stands after the closing byte.
    assign frame_ok = !discard_next
                   && (len_next != 8'd0)
                   && (len_new + ccfd_pkg::POS_W'(1) < ccfd_pkg::POS_W'(ccfd_pkg::FRAME_CAP))
                   && ({2'b00, count_next} >= len_new + ccfd_pkg::POS_W'(2))
                   && matched_next
                   && (addr_next == ccfd_pkg::ADDR_RC)
                   && (type_next == ccfd_pkg::TYPE_RC)
                   && (len_next >= ccfd_pkg::MIN_RC_LEN);

    assign fq_wr.push  = accept && end_of_frame && frame_ok;
    assign fq_wr.bytes = ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            addr_reg    <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            crc_reg     <= '0;
            matched_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else if (accept && end_of_frame)
        begin
            count_reg   <= '0;
            addr_reg    <= '0;
            len_reg     <= '0;
            type_reg    <= '0;
            crc_reg     <= '0;
            matched_reg <= 1'b0;
            discard_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            len_reg     <= len_next;
            type_reg    <= type_next;
            crc_reg     <= crc_next;
            matched_reg <= matched_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

`ifndef SYNTHESIS
    a_count_cleared_after_eof: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && end_of_frame) |=> (count_reg == '0 && !discard_reg && !matched_reg)
    ) else $error("frame state not cleared after frame end");
`endif

endmodule

>>> sv/ccfd_frame_queue.sv
module ccfd_frame_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ccfd_pkg::fq_wr_t    wr,
    output logic                full,
    input  logic                pop,
    output ccfd_pkg::fq_rd_t    rd
);

    localparam int PTR_W = $clog2(ccfd_pkg::FQ_DEPTH);
    localparam int CNT_W = $clog2(ccfd_pkg::FQ_DEPTH + 1);

    ccfd_pkg::ch_bytes_t  mem_reg [ccfd_pkg::FQ_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (cnt_reg == CNT_W'(ccfd_pkg::FQ_DEPTH));
    assign rd.valid = (cnt_reg != '0);
    assign rd.bytes = mem_reg[rd_ptr_reg];
    assign do_wr    = wr.push && !full;
    assign do_rd    = pop && rd.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ccfd_pkg::FQ_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ccfd_pkg::FQ_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr.bytes;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ccfd_pkg::FQ_DEPTH)
    ) else $error("frame queue count out of range");
`endif

endmodule

>>> sv/ccfd_back.sv
module ccfd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ccfd_pkg::fq_rd_t                    fq_rd,
    output logic                                fq_pop,
    input  logic [ccfd_pkg::SCALE_W-1:0]        scale_mult,
    input  logic [ccfd_pkg::SCALE_W-1:0]        scale_div,
    input  logic [ccfd_pkg::SCALE_W-1:0]        scale_offset,
    input  logic                                pop,
    output logic                                empty,
    output logic [ccfd_pkg::CH_IDX_W-1:0]       channel_index,
    output logic [ccfd_pkg::VALUE_W-1:0]        channel_value,
    output logic                                last_channel
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } back_state_t;

    localparam int REM_W = ccfd_pkg::SCALE_W + 1;

    back_state_t                        state_reg, state_next;
    ccfd_pkg::ch_bytes_t                sr_reg, sr_next;
    logic [ccfd_pkg::CH_IDX_W-1:0]      ch_reg, ch_next;
    logic [ccfd_pkg::VALUE_W-1:0]       quo_reg, quo_next;
    logic [REM_W-1:0]                   rem_reg, rem_next;
    logic [ccfd_pkg::DIV_CNT_W-1:0]     step_reg, step_next;
    logic                               out_valid_reg, out_valid_next;
    logic [ccfd_pkg::CH_IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [ccfd_pkg::VALUE_W-1:0]       out_val_reg, out_val_next;
    logic                               out_last_reg, out_last_next;
    logic [ccfd_pkg::SCALE_W-1:0]       divisor;
    logic [REM_W-1:0]                   rem_shift;
    logic                               rem_ge;
    logic                               out_free;
    logic                               is_last;

    assign divisor   = (scale_div == '0) ? ccfd_pkg::SCALE_W'(1) : scale_div;
    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[ccfd_pkg::VALUE_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor});
    assign out_free  = !out_valid_reg || pop;
    assign is_last   = (ch_reg == ccfd_pkg::CH_IDX_W'(ccfd_pkg::NUM_CHANNELS - 1));

    always_comb
    begin
        state_next     = state_reg;
        sr_next        = sr_reg;
        ch_next        = ch_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        fq_pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fq_rd.valid)
                begin
                    fq_pop     = 1'b1;
                    sr_next    = fq_rd.bytes;
                    ch_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                quo_next   = ccfd_pkg::VALUE_W'(sr_reg[ccfd_pkg::CH_BITS-1:0]) *
                             ccfd_pkg::VALUE_W'(scale_mult);
                rem_next   = '0;
                step_next  = ccfd_pkg::DIV_CNT_W'(ccfd_pkg::VALUE_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle, MSB first.
                rem_next  = rem_ge ? rem_shift - {1'b0, divisor} : rem_shift;
                quo_next  = {quo_reg[ccfd_pkg::VALUE_W-2:0], rem_ge};
                step_next = step_reg - ccfd_pkg::DIV_CNT_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = ch_reg;
                    out_val_next   = quo_reg + ccfd_pkg::VALUE_W'(scale_offset);
                    out_last_next  = is_last;
                    ch_next        = ch_reg + ccfd_pkg::CH_IDX_W'(1);
                    sr_next        = sr_reg >> ccfd_pkg::CH_BITS;
                    state_next     = is_last ? S_IDLE : S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg       <= sr_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign empty         = !out_valid_reg;
    assign channel_index = out_idx_reg;
    assign channel_value = out_val_reg;
    assign last_channel  = out_last_reg;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && (step_reg != ccfd_pkg::DIV_CNT_W'(ccfd_pkg::VALUE_W - 1))
        |-> (rem_reg < {1'b0, divisor})
    ) else $error("division remainder not below divisor");

    a_last_ends_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free && is_last) |=> (state_reg == S_IDLE && last_channel)
    ) else $error("last channel did not end the run");

    a_idle_no_result_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !fq_rd.valid) |=> (state_reg == S_IDLE)
    ) else $error("back end left idle without a frame");
`endif

endmodule

>>> sv/crsf_channel_frame_decoder.sv
// Channel   Handshake               Word contents
// input     push / full             data_byte, end_of_frame, line_error
// result    empty / pop             channel_index, channel_value, last_channel
// config    cfg_write (no wait)     cfg_index, cfg_data
//
// The front end takes one byte per cycle while full is low and finishes a frame check
// on the closing byte. Each decoded channel then passes through the back end as a
// multiply step, the bit-serial divider and an output step; a frame is first fetched
// from the queue, and a finished result may wait in the output register for pop.
// A two-entry frame queue holds finished frames; full stays high while it has no room.
// Reset clears all control state and loads the register reset values.
module crsf_channel_frame_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_frame,
    input  logic                                line_error,
    output logic                                empty,
    input  logic                                pop,
    output logic [ccfd_pkg::CH_IDX_W-1:0]       channel_index,
    output logic [ccfd_pkg::VALUE_W-1:0]        channel_value,
    output logic                                last_channel,
    input  logic                                cfg_write,
    input  logic [ccfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ccfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [7:0]                      crc_poly_reg;
    logic [ccfd_pkg::SCALE_W-1:0]    scale_mult_reg;
    logic [ccfd_pkg::SCALE_W-1:0]    scale_div_reg;
    logic [ccfd_pkg::SCALE_W-1:0]    scale_offset_reg;
    ccfd_pkg::fq_wr_t                fq_wr;
    ccfd_pkg::fq_rd_t                fq_rd;
    logic                            fq_full;
    logic                            fq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_poly_reg     <= ccfd_pkg::CRC_POLY_RESET;
            scale_mult_reg   <= ccfd_pkg::SCALE_MULT_RESET;
            scale_div_reg    <= ccfd_pkg::SCALE_DIV_RESET;
            scale_offset_reg <= ccfd_pkg::SCALE_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (ccfd_pkg::cfg_reg_t'(cfg_index))
                ccfd_pkg::REG_CRC_POLY:     crc_poly_reg     <= cfg_data[7:0];
                ccfd_pkg::REG_SCALE_MULT:   scale_mult_reg   <= cfg_data;
                ccfd_pkg::REG_SCALE_DIV:    scale_div_reg    <= cfg_data;
                ccfd_pkg::REG_SCALE_OFFSET: scale_offset_reg <= cfg_data;
                default:                    crc_poly_reg     <= crc_poly_reg;
            endcase
        end
    end

    assign full = fq_full;

    ccfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (fq_full),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .line_error   (line_error),
        .crc_poly     (crc_poly_reg),
        .fq_wr        (fq_wr)
    );

    ccfd_frame_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fq_wr),
        .full  (fq_full),
        .pop   (fq_pop),
        .rd    (fq_rd)
    );

    ccfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fq_rd         (fq_rd),
        .fq_pop        (fq_pop),
        .scale_mult    (scale_mult_reg),
        .scale_div     (scale_div_reg),
        .scale_offset  (scale_offset_reg),
        .pop           (pop),
        .empty         (empty),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        fq_full |-> !fq_wr.push
    ) else $error("frame written while queue full");
`endif

endmodule
